@@ rtl/h74d_pkg.sv @@
// ----------------------------------------------------------------------------
// h74d_pkg
// Shared types, sizes and the codeword repair function for the Hamming (7,4)
// stream decoder.
// ----------------------------------------------------------------------------
package h74d_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 1024;
    localparam int unsigned FRAME_W         = 11;
    localparam int unsigned TOTAL_W         = 12;
    localparam int unsigned STORE_W         = 13;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned WORD_W          = 14;
    localparam int unsigned CW_W            = 7;

    localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_FRAME_BYTES);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] coded_byte;
    } item_t;

    typedef struct packed {
        logic               short_frame;
        logic               frame_last;
        logic [TOTAL_W-1:0] correction_total;
        logic [1:0]         corrections_here;
        logic [7:0]         data_byte;
    } result_t;

    typedef struct packed {
        logic       fixed;
        logic [3:0] nibble;
    } nibble_t;

    // Bit 6 is p1, bit 0 is d4; a nonzero syndrome names the bad position.
    function automatic nibble_t fix_codeword(input logic [CW_W-1:0] cw);
        logic [2:0]      syn;
        logic [CW_W-1:0] c;
        nibble_t         r;
        syn[0] = cw[6] ^ cw[4] ^ cw[2] ^ cw[0];
        syn[1] = cw[5] ^ cw[4] ^ cw[1] ^ cw[0];
        syn[2] = cw[3] ^ cw[2] ^ cw[1] ^ cw[0];
        c = cw;
        if (syn != 3'd0) begin
            c = cw ^ (CW_W'(1) << (3'd7 - syn));
        end
        r.fixed  = (syn != 3'd0);
        r.nibble = {c[4], c[2], c[1], c[0]};
        return r;
    endfunction

endpackage

@@ rtl/hamming74_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// hamming74_stream_decoder
// Path: a coded byte accepted on s_* is held in the input register, then goes
//   through decode logic into the result register that drives m_*.
// Throughput: one coded byte per cycle; the input register advances whenever
//   the result register is empty or its transfer completes in that cycle.
// Reset: aresetn low at a clock edge clears all frame state and both valid
//   flags and sets frame_bytes to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module hamming74_stream_decoder
    import h74d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // frame length register
    input  logic               cfg_wr_en,
    input  logic [FRAME_W-1:0] cfg_wr_data,
    // coded input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] coded_byte
    input  logic               s_tlast,   // frame_end
    // decoded output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // [7:0] data_byte, [9:8] corrections_here,
                                          // [21:10] correction_total, [23:22] zero
    output logic               m_tlast,   // frame_last
    output logic [0:0]         m_tuser    // [0] short_frame
);

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    advance;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // Move the held byte through decode when the result register can take it.
    assign advance = item_valid && out_free;

    h74d_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Unpack, repair both codewords and track frame position in one pass.
    h74d_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Hold the result until the downstream transfer completes.
    h74d_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res.correction_total, out_res.corrections_here,
                      out_res.data_byte};
    assign m_tlast = out_res.frame_last;
    assign m_tuser = out_res.short_frame;

endmodule

@@ rtl/h74d_in_reg.sv @@
// ----------------------------------------------------------------------------
// h74d_in_reg
// Input register: holds one coded byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module h74d_in_reg
    import h74d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.coded_byte <= s_tdata;
            item_reg.frame_end  <= s_tlast;
        end
    end

endmodule

@@ rtl/h74d_frame.sv @@
// ----------------------------------------------------------------------------
// h74d_frame
// Bit unpacking, codeword repair and frame bookkeeping for one coded byte.
// ----------------------------------------------------------------------------
module h74d_frame
    import h74d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FRAME_W-1:0] cfg_wr_data,
    input  logic               advance,
    input  item_t              item,
    output logic               res_valid,
    output result_t            res
);

    logic [FRAME_W-1:0] frame_bytes_reg;
    logic [STORE_W-1:0] bit_store_reg, bit_store_next;
    logic [COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [FRAME_W-1:0] bytes_done_reg, bytes_done_next;
    logic [TOTAL_W-1:0] correction_sum_reg, correction_sum_next;
    logic               discarding_reg, discarding_next;

    logic [STORE_W+7:0] acc;
    logic [4:0]         total;
    logic               full;
    logic [2:0]         rsh;
    logic [2:0]         lsh;
    logic [WORD_W-1:0]  word;
    nibble_t            hi, lo;
    logic [1:0]         fixed;
    logic [TOTAL_W:0]   sum_wide;
    logic [TOTAL_W-1:0] sum_sat;
    logic [FRAME_W:0]   bytes_inc;
    logic               last_raw;
    logic               emit;

    always_comb begin
        acc      = {bit_store_reg, item.coded_byte};
        total    = {1'b0, bit_count_reg} + 5'd8;
        full     = (total >= 5'd14);
        rsh      = 3'(total - 5'd14);
        lsh      = 3'(5'd14 - total);
        if (full) begin
            word = WORD_W'(acc >> rsh);
        end else begin
            word = WORD_W'(acc << lsh);
        end
        hi       = fix_codeword(word[13:7]);
        lo       = fix_codeword(word[6:0]);
        fixed    = {1'b0, hi.fixed} + {1'b0, lo.fixed};
        sum_wide = {1'b0, correction_sum_reg} + (TOTAL_W+1)'(fixed);
        sum_sat  = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
        bytes_inc = {1'b0, bytes_done_reg} + (FRAME_W+1)'(1);
        last_raw = (bytes_inc >= {1'b0, frame_bytes_reg});
        emit     = !discarding_reg && (full || item.frame_end);

        res.data_byte        = {hi.nibble, lo.nibble};
        res.corrections_here = fixed;
        res.correction_total = sum_sat;
        res.frame_last       = last_raw || item.frame_end;
        res.short_frame      = !full || (!last_raw && item.frame_end);
        res_valid            = emit;
    end

    always_comb begin
        bit_store_next      = bit_store_reg;
        bit_count_next      = bit_count_reg;
        bytes_done_next     = bytes_done_reg;
        correction_sum_next = correction_sum_reg;
        discarding_next     = discarding_reg;
        if (discarding_reg || item.frame_end) begin
            // Frame end clears everything, emitted or dropped.
            if (item.frame_end) begin
                bit_store_next      = '0;
                bit_count_next      = '0;
                bytes_done_next     = '0;
                correction_sum_next = '0;
                discarding_next     = 1'b0;
            end
        end else if (full) begin
            bit_store_next      = STORE_W'(acc & ((21'd1 << rsh) - 21'd1));
            bit_count_next      = COUNT_W'(rsh);
            bytes_done_next     = bytes_inc[FRAME_W-1:0];
            correction_sum_next = sum_sat;
            if (last_raw) begin
                discarding_next = 1'b1;
                bit_store_next  = '0;
                bit_count_next  = '0;
            end
        end else begin
            bit_store_next = acc[STORE_W-1:0];
            bit_count_next = total[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg    <= FRAME_W'(1);
            bit_store_reg      <= '0;
            bit_count_reg      <= '0;
            bytes_done_reg     <= '0;
            correction_sum_reg <= '0;
            discarding_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_data == '0) begin
                    frame_bytes_reg <= FRAME_W'(1);
                end else if (cfg_wr_data > FRAME_MAX) begin
                    frame_bytes_reg <= FRAME_MAX;
                end else begin
                    frame_bytes_reg <= cfg_wr_data;
                end
            end
            if (advance) begin
                bit_store_reg      <= bit_store_next;
                bit_count_reg      <= bit_count_next;
                bytes_done_reg     <= bytes_done_next;
                correction_sum_reg <= correction_sum_next;
                discarding_reg     <= discarding_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= COUNT_W'(13))
        else $error("bit count out of range");

    a_discard_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg |-> (bit_count_reg == '0) && (bit_store_reg == '0))
        else $error("bits held while discarding");

    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_done_reg <= FRAME_MAX)
        else $error("byte count beyond frame limit");

    a_short_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.short_frame) |-> res.frame_last)
        else $error("short byte not marked last");
`endif

endmodule

@@ rtl/h74d_out_reg.sv @@
// ----------------------------------------------------------------------------
// h74d_out_reg
// Result register: holds a decoded byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module h74d_out_reg
    import h74d_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  logic    res_valid,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign out_res  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res_valid;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hamming74_stream_decoder. Coded frames are built by
// encoding random nibbles, flipping zero, one or two bits per codeword and
// packing the bits MSB first. Frames end cleanly, carry extra pad bytes, end
// early, lose their end marker or are replaced by plain noise. Every accepted
// coded byte is run through an in-bench decoder model; each decoded byte on
// the output is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import h74d_pkg::*;

    // ------------------------------------------------------------------------
    // Decoder model and checker: holds its own copy of the frame state and
    // queues one predicted byte for every coded byte that completes one.
    // ------------------------------------------------------------------------
    class decoded_byte_board;
        result_t          expected_bytes[$];
        int unsigned      frame_len;
        logic [12:0]      bits_held;
        logic [3:0]       bits_valid;
        logic [10:0]      bytes_out;
        logic [11:0]      fix_total;
        bit               dropping;
        int unsigned      mismatch_count;
        int unsigned      bytes_checked;
        int unsigned      short_seen;
        int unsigned      fixes_seen;

        function new();
            frame_len = 1;
            clear_frame();
        endfunction

        function void clear_frame();
            bits_held  = '0;
            bits_valid = '0;
            bytes_out  = '0;
            fix_total  = '0;
            dropping   = 1'b0;
        endfunction

        // Zero counts as one; anything past the maximum is clipped.
        function void set_length(input logic [FRAME_W-1:0] v);
            if (v == '0) begin
                frame_len = 1;
            end else if (v > MAX_FRAME_BYTES) begin
                frame_len = MAX_FRAME_BYTES;
            end else begin
                frame_len = v;
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // Syndrome is the XOR of the 1-based positions of all set bits;
        // position 1 is the MSB (p1).
        function void repair(input logic [6:0] cw, output logic [3:0] nib, output bit hit);
            logic [2:0] syn;
            logic [6:0] c;
            syn = '0;
            for (int pos = 1; pos <= 7; pos++) begin
                if (cw[7-pos]) syn ^= 3'(pos);
            end
            c   = cw;
            hit = (syn != '0);
            if (hit) c[7-syn] = ~c[7-syn];
            nib = {c[4], c[2], c[1], c[0]};
        endfunction

        function void note_coded_byte(input logic [7:0] b, input logic fe);
            logic [20:0] acc;
            logic [13:0] word;
            logic [3:0]  hi, lo;
            bit          hit_hi, hit_lo, last, shrt;
            int unsigned nbits, sum;
            result_t     r;
            shrt = 1'b0;
            // past the frame's last byte: drop until the end marker
            if (dropping) begin
                if (fe) clear_frame();
                return;
            end
            acc   = {bits_held, b};
            nbits = bits_valid + 8;
            if (nbits >= 14) begin
                word       = 14'(acc >> (nbits - 14));
                bits_held  = 13'(acc & ((21'd1 << (nbits - 14)) - 1));
                bits_valid = 4'(nbits - 14);
            end else if (fe) begin
                // early end with a partial byte: zero-fill to a full pair
                word       = 14'(acc << (14 - nbits));
                bits_held  = '0;
                bits_valid = '0;
                shrt       = 1'b1;
            end else begin
                bits_held  = acc[12:0];
                bits_valid = 4'(nbits);
                return;
            end
            repair(word[13:7], hi, hit_hi);
            repair(word[6:0], lo, hit_lo);
            sum = fix_total + hit_hi + hit_lo;
            if (sum > 4095) sum = 4095;
            fix_total = 12'(sum);
            bytes_out++;
            last = (bytes_out >= frame_len);
            if (!last && fe) begin
                shrt = 1'b1;
                last = 1'b1;
            end
            r.data_byte        = {hi, lo};
            r.corrections_here = 2'(hit_hi) + 2'(hit_lo);
            r.correction_total = fix_total;
            r.frame_last       = last;
            r.short_frame      = shrt;
            expected_bytes = {expected_bytes, r};
            if (fe) begin
                clear_frame();
            end else if (last) begin
                dropping   = 1'b1;
                bits_held  = '0;
                bits_valid = '0;
            end
        endfunction

        task report(input string what, input int unsigned want, input int unsigned got);
            $display("mismatch at %0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatch_count++;
        endtask

        task check_decoded(input logic [23:0] data, input logic last, input logic shrt);
            result_t want;
            if (expected_bytes.size() == 0) begin
                report("decoded byte with nothing pending", 0, data);
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want.short_frame) short_seen++;
            if (want.corrections_here != 0) fixes_seen++;
            if (data[7:0] !== want.data_byte)
                report("data_byte", want.data_byte, data[7:0]);
            if (data[9:8] !== want.corrections_here)
                report("corrections_here", want.corrections_here, data[9:8]);
            if (data[21:10] !== want.correction_total)
                report("correction_total", want.correction_total, data[21:10]);
            if (data[23:22] !== 2'b00)
                report("tdata pad bits", 0, data[23:22]);
            if (last !== want.frame_last)
                report("frame_last", want.frame_last, last);
            if (shrt !== want.short_frame)
                report("short_frame", want.short_frame, shrt);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [FRAME_W-1:0] cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata     = '0;   // [7:0] coded_byte
    logic               s_tlast     = 1'b0; // frame_end
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [23:0]        m_tdata;            // [7:0] data_byte, [9:8] corrections_here,
                                            // [21:10] correction_total, [23:22] zero
    logic               m_tlast;            // frame_last
    logic [0:0]         m_tuser;            // [0] short_frame

    decoded_byte_board board = new();

    int unsigned src_idle_pct = 28;
    int unsigned dst_idle_pct = 61;
    int unsigned coded_sent   = 0;
    int unsigned hold_left    = 0;
    logic        hold_req     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hamming74_stream_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, plus a long hold on request so the
    // result register fills and the block has to stall its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 120;
            hold_req <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Check every output transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_decoded(m_tdata, m_tlast, m_tuser[0]);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one coded byte, idling at random first; return at the edge that
    // completes the transfer and feed it to the model there.
    task automatic send_item(input logic [7:0] b, input bit fe);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fe;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_coded_byte(b, fe);
        coded_sent++;
    endtask

    // Stop sending, wait for every pending result, then let the pipeline
    // flush any byte that produced nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Only called once the block is idle
    task automatic write_length(input logic [FRAME_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        board.set_length(v);
        cfg_wr_en   <= 1'b0;
    endtask

    // Build one coded frame of fb data bytes (few when fb is large) and send
    // it in one of several shapes.
    task automatic send_frame(input int unsigned fb);
        logic [7:0]  packed_bytes[$];
        logic [7:0]  acc;
        logic [6:0]  cw;
        logic [3:0]  d;
        int unsigned n_data, roll, cut, nb, err;
        roll = $urandom_range(99);
        // plain noise with random end markers
        if (roll >= 94) begin
            repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
            return;
        end
        n_data = (fb <= 48) ? fb : $urandom_range(1, 8);
        acc = '0;
        nb  = 0;
        for (int i = 0; i < 2 * n_data; i++) begin
            d  = 4'($urandom_range(15));
            cw = {d[3] ^ d[2] ^ d[0], d[3] ^ d[1] ^ d[0], d[3],
                  d[2] ^ d[1] ^ d[0], d[2], d[1], d[0]};
            // mostly clean or one flipped bit; now and then two (miscorrects)
            err = $urandom_range(9);
            if (err < 4) begin
                cw[$urandom_range(6)] ^= 1'b1;
            end else if (err == 9) begin
                cw[$urandom_range(6)] ^= 1'b1;
                cw[$urandom_range(6)] ^= 1'b1;
            end
            for (int k = 6; k >= 0; k--) begin
                acc = {acc[6:0], cw[k]};
                nb++;
                if (nb == 8) begin
                    packed_bytes = {packed_bytes, acc};
                    nb = 0;
                end
            end
        end
        // random pad bits in the tail byte
        if (nb != 0) begin
            acc = (acc << (8 - nb)) | 8'($urandom_range((1 << (8 - nb)) - 1));
            packed_bytes = {packed_bytes, acc};
        end
        if (roll < 70) begin
            // whole frame, sometimes followed by pad bytes the block drops once the frame length is reached
            if ($urandom_range(1) == 1) begin
                repeat ($urandom_range(1, 3))
                    packed_bytes = {packed_bytes, 8'($urandom_range(255))};
            end
            cut = packed_bytes.size();
        end else if (roll < 88) begin
            // early end, anywhere inside the frame
            cut = $urandom_range(1, packed_bytes.size() - 1);
        end else begin
            // end marker lost: the next frame gets swallowed
            cut = packed_bytes.size();
        end
        for (int i = 0; i < cut; i++) begin
            send_item(packed_bytes[i], (roll < 88) && (i == cut - 1));
        end
    endtask

    // Frame length per phase: both extremes, out-of-range writes, small mix
    function automatic logic [FRAME_W-1:0] pick_length(input int unsigned phase);
        case (phase % 9)
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3:       return FRAME_W'($urandom_range(4, 20));
            4:       return 0;
            5:       return '1;
            6:       return FRAME_W'(MAX_FRAME_BYTES + 1);
            7:       return FRAME_MAX;
            default: return FRAME_W'($urandom_range(1, 48));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned mode_start, phase_start, phase;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset length of one: byte then leftovers dropped until the marker
        send_item(8'h00, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h55, 1'b1);
        // frame end on the frame's last byte
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // end with a partial byte: zero-fill and flag short
        send_item(8'hA5, 1'b1);
        settle();

        // shorten the frame while it is in flight
        write_length(4);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h56, 1'b0);
        send_item(8'h78, 1'b0);
        settle();
        write_length(2);
        send_item(8'h9A, 1'b0);
        send_item(8'hBC, 1'b0);
        send_item(8'hDE, 1'b1);
        settle();

        // early end on a byte that completes a decoded byte
        write_length(3);
        send_item(8'h00, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h0F, 1'b0);
        send_item(8'hF0, 1'b1);

        // Random part: three idle patterns, each through all length settings
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 28 : (mode == 1) ? 61 : 0;
            dst_idle_pct = (mode == 0) ? 61 : (mode == 1) ? 28 : 0;
            mode_start   = coded_sent;
            phase        = 0;
            while (coded_sent - mode_start < 500) begin
                settle();
                write_length(pick_length(phase));
                phase_start = coded_sent;
                if (phase == 2) hold_req <= 1'b1;
                while (coded_sent - phase_start < 55) send_frame(board.frame_len);
                phase++;
            end
        end

        settle();
        repeat (16) @(posedge aclk);
        $display("Run covered %0d coded bytes and %0d decoded bytes (%0d short, %0d repaired)",
                 coded_sent, board.bytes_checked, board.short_seen, board.fixes_seen);
        $display("Frame lengths 1 to %0d, out-of-range writes, mid-frame length change, stalls",
                 MAX_FRAME_BYTES);
        if (board.mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
